// ----- src/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the three-rotor shift cipher
// Beat payload structs, rotor position bundle, register indexes and the
// fixed rotor table.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int unsigned POS_W = 4;
   localparam int unsigned KEY_W = 5;
   localparam int unsigned IDX_W = 5;

   localparam logic [POS_W-1:0] POS_LAST    = 4'd9;
   localparam logic [IDX_W-1:0] ALPHA_LEN   = 5'd27;
   localparam logic [IDX_W-1:0] SPACE_INDEX = 5'd26;
   localparam logic [7:0]       SPACE_CHAR  = 8'h20;
   localparam logic [7:0]       CHAR_A      = 8'h41;
   localparam logic [7:0]       CHAR_Z      = 8'h5a;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS_FAST   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS_MIDDLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS_SLOW   = 2'd3;

   typedef struct packed {
      logic [7:0] char_in;
      logic       message_start;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       not_in_alphabet;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0] fast;
      logic [POS_W-1:0] middle;
      logic [POS_W-1:0] slow;
   } pos_type;

   // Rotor wiring table; positions outside 0..9 contribute nothing.
   function automatic logic [KEY_W-1:0] rotor_value(input logic [POS_W-1:0] pos);
      logic [KEY_W-1:0] val;
      case (pos)
         4'd0:    val = 5'd7;
         4'd1:    val = 5'd3;
         4'd2:    val = 5'd0;
         4'd3:    val = 5'd1;
         4'd4:    val = 5'd9;
         4'd5:    val = 5'd5;
         4'd6:    val = 5'd2;
         4'd7:    val = 5'd6;
         4'd8:    val = 5'd4;
         4'd9:    val = 5'd8;
         default: val = 5'd0;
      endcase
      return val;
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(input logic [CSR_DATA_W-1:0] v);
      return (v > POS_LAST) ? POS_LAST : v;
   endfunction

endpackage

// ----- src/rsc_rotor.sv -----
// ----------------------------------------------------------------------------
// rsc_rotor: rotor position registers and key generation
// Holds the three decade rotors, reloads them on a message start, forms the
// key from the current positions and steps them like an odometer per beat.
// ----------------------------------------------------------------------------
module rsc_rotor
   import rsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             load,
   input  pos_type          start_pos,
   output logic [KEY_W-1:0] key
);

   pos_type pos_ff, pos_in;
   pos_type eff;

   always_comb begin
      eff = load ? start_pos : pos_ff;
      key = rotor_value(eff.fast) + rotor_value(eff.middle) + rotor_value(eff.slow);

      pos_in = eff;
      if (eff.fast >= POS_LAST) begin
         pos_in.fast = '0;
         if (eff.middle >= POS_LAST) begin
            pos_in.middle = '0;
            pos_in.slow   = (eff.slow >= POS_LAST) ? '0 : eff.slow + 4'd1;
         end else begin
            pos_in.middle = eff.middle + 4'd1;
         end
      end else begin
         pos_in.fast = eff.fast + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff.fast <= POS_LAST && pos_ff.middle <= POS_LAST && pos_ff.slow <= POS_LAST)
      else $error("rotor position left the decade range");

   a_reload_step: assert property (@(posedge clock) disable iff (reset)
      advance && load && start_pos.fast < POS_LAST
      |=> pos_ff.fast == $past(start_pos.fast) + 4'd1 && pos_ff.middle == $past(start_pos.middle))
      else $error("message start did not reload and step the rotors");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pos_ff))
      else $error("rotors moved without a beat");

endmodule

// ----- src/rsc_shift.sv -----
// ----------------------------------------------------------------------------
// rsc_shift: character decode, modular shift and encode
// Maps A-Z and space to 0..26, moves the index by the key modulo 27 and
// maps it back; other characters pass through flagged.
// ----------------------------------------------------------------------------
module rsc_shift
   import rsc_pkg::*;
(
   input  logic [7:0]       char_in,
   input  logic [KEY_W-1:0] key,
   input  logic             decrypt,
   output rsp_type          result
);

   logic             valid;
   logic [IDX_W-1:0] idx;
   logic [IDX_W:0]   sum;
   logic [IDX_W-1:0] n;

   always_comb begin
      valid = 1'b1;
      idx   = '0;
      if (char_in inside {[CHAR_A:CHAR_Z]}) begin
         idx = IDX_W'(char_in - CHAR_A);
      end else if (char_in == SPACE_CHAR) begin
         idx = SPACE_INDEX;
      end else begin
         valid = 1'b0;
      end

      // The key never exceeds 27, so the decrypt sum stays non-negative.
      if (decrypt) begin
         sum = {1'b0, idx} + {1'b0, ALPHA_LEN} - {1'b0, key};
      end else begin
         sum = {1'b0, idx} + {1'b0, key};
      end
      n = (sum >= {1'b0, ALPHA_LEN}) ? IDX_W'(sum - {1'b0, ALPHA_LEN}) : sum[IDX_W-1:0];

      if (!valid) begin
         result.char_out = char_in;
      end else if (n == SPACE_INDEX) begin
         result.char_out = SPACE_CHAR;
      end else begin
         result.char_out = CHAR_A + {3'b000, n};
      end
      result.not_in_alphabet = !valid;
   end

endmodule

// ----- src/three_rotor_shift_cipher.sv -----
// ----------------------------------------------------------------------------
// three_rotor_shift_cipher: 27-symbol three-rotor shift cipher
// Encrypts or decrypts one ASCII character per beat with a stepping key.
// ----------------------------------------------------------------------------
// Usage: characters enter as req beats (req_valid / req_stall) and results
// leave as rsp beats (rsp_valid / rsp_stall), one result for every request.
// A beat with message_start set reloads the rotors from the start position
// registers before that character is handled. Configuration goes through the
// csr write port and should only be changed while no beats are in flight.
//
// A request taken into the input stage has its result registered in the
// result register next, which presents it on rsp until the receiver takes it.
// Throughput is one character per cycle unless rsp_stall holds it; the rotor
// step and key lookup finish in the accept cycle and the modular shift in the
// next, so nothing loops back across beats except the rotor registers.
//
// Reset clears the rotors, the CSRs and both stage valid bits. When the
// receiver stalls, the result register holds its beat and the input stage
// still fills, so req_stall rises only once both stages are occupied.
// ----------------------------------------------------------------------------
module three_rotor_shift_cipher
   import rsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic    decrypt_ff;
   pos_type start_ff;

   // Input stage: character and the key that belongs to it.
   logic             s1_valid_ff;
   logic [7:0]       s1_char_ff;
   logic [KEY_W-1:0] s1_key_ff;

   // Result stage.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic             out_free;
   logic             s1_free;
   logic             req_take;
   logic [KEY_W-1:0] key;
   rsp_type          result;

   // The result register frees up when it is empty or its beat is taken;
   // the input stage frees up when it is empty or can move forward.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign req_take  = req_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_ff <= 1'b0;
         start_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DECRYPT_MODE:     decrypt_ff      <= csr_wdata[0];
            CSR_START_POS_FAST:   start_ff.fast   <= clamp_pos(csr_wdata);
            CSR_START_POS_MIDDLE: start_ff.middle <= clamp_pos(csr_wdata);
            CSR_START_POS_SLOW:   start_ff.slow   <= clamp_pos(csr_wdata);
            default:              ;
         endcase
      end
   end

   // The rotors step on every accepted beat, valid character or not.
   rsc_rotor u_rotor (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_take),
      .load      (req_data.message_start),
      .start_pos (start_ff),
      .key       (key)
   );

   rsc_shift u_shift (
      .char_in (s1_char_ff),
      .key     (s1_key_ff),
      .decrypt (decrypt_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_data.char_in;
         s1_key_ff  <= key;
      end
      if (out_free && s1_valid_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_char_ff) && $stable(s1_key_ff))
      else $error("input stage lost a beat while the output was blocked");

   a_in_alphabet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.not_in_alphabet
      |-> (rsp_data_ff.char_out >= CHAR_A && rsp_data_ff.char_out <= CHAR_Z)
          || rsp_data_ff.char_out == SPACE_CHAR)
      else $error("result character outside the alphabet");

endmodule

// ----- tb/rsc_cipher_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsc_cipher_checker: result predictor and scoreboard for the rotor cipher
// Follows the register writes and the accepted request beats, keeps its own
// rotor state, and compares every accepted result beat with the oldest
// predicted character.
// ----------------------------------------------------------------------------
module rsc_cipher_checker
   import rsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           pending_beats,
   output int unsigned           result_count
);

   pos_type  rotor;
   pos_type  start_pos;
   logic     decrypt_on;
   rsp_type  expected_chars[$];

   function automatic int unsigned wiring_at(input logic [POS_W-1:0] pos);
      int unsigned val;
      case (pos)
         4'd0:    val = 7;
         4'd1:    val = 3;
         4'd2:    val = 0;
         4'd3:    val = 1;
         4'd4:    val = 9;
         4'd5:    val = 5;
         4'd6:    val = 2;
         4'd7:    val = 6;
         4'd8:    val = 4;
         4'd9:    val = 8;
         default: val = 0;
      endcase
      return val;
   endfunction

   function automatic logic [POS_W-1:0] limit_pos(input logic [CSR_DATA_W-1:0] v);
      return (v > POS_LAST) ? POS_LAST : v[POS_W-1:0];
   endfunction

   // Odometer step: fast every character, middle on a fast wrap, slow on a
   // middle wrap.
   function automatic pos_type advance(input pos_type p);
      pos_type q;
      q = p;
      if (q.fast == POS_LAST) begin
         q.fast = '0;
         if (q.middle == POS_LAST) begin
            q.middle = '0;
            q.slow = (q.slow == POS_LAST) ? '0 : q.slow + 1'b1;
         end else begin
            q.middle = q.middle + 1'b1;
         end
      end else begin
         q.fast = q.fast + 1'b1;
      end
      return q;
   endfunction

   function automatic rsp_type cipher_char(input logic [7:0] ch, input logic decrypt,
                                           input pos_type at);
      int unsigned key;
      int          idx;
      int unsigned n;
      rsp_type     r;
      key = wiring_at(at.fast) + wiring_at(at.middle) + wiring_at(at.slow);
      if (ch >= CHAR_A && ch <= CHAR_Z)
         idx = int'(ch) - int'(CHAR_A);
      else if (ch == SPACE_CHAR)
         idx = int'(SPACE_INDEX);
      else
         idx = -1;
      if (idx < 0) begin
         r.char_out        = ch;
         r.not_in_alphabet = 1'b1;
      end else begin
         if (decrypt)
            n = (idx + int'(ALPHA_LEN) - key) % int'(ALPHA_LEN);
         else
            n = (idx + key) % int'(ALPHA_LEN);
         r.char_out        = (n == SPACE_INDEX) ? SPACE_CHAR : 8'(CHAR_A + n);
         r.not_in_alphabet = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < 40)
         $display("%0t ns: mismatch: %s", $realtime, what);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         rotor      = '0;
         start_pos  = '0;
         decrypt_on = 1'b0;
         expected_chars.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DECRYPT_MODE:     decrypt_on       = csr_wdata[0];
               CSR_START_POS_FAST:   start_pos.fast   = limit_pos(csr_wdata);
               CSR_START_POS_MIDDLE: start_pos.middle = limit_pos(csr_wdata);
               CSR_START_POS_SLOW:   start_pos.slow   = limit_pos(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing outstanding",
                                         rsp_data));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.char_out !== want.char_out)
                  report_mismatch($sformatf("char_out is %h, expected %h",
                                            rsp_data.char_out, want.char_out));
               if (rsp_data.not_in_alphabet !== want.not_in_alphabet)
                  report_mismatch($sformatf("not_in_alphabet is %b, expected %b",
                                            rsp_data.not_in_alphabet,
                                            want.not_in_alphabet));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.message_start)
               rotor = start_pos;
            expected_chars.push_back(cipher_char(req_data.char_in, decrypt_on, rotor));
            rotor = advance(rotor);
         end
      end
      pending_beats <= expected_chars.size();
   end

endmodule

// ----- tb/tb_three_rotor_shift_cipher.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_rotor_shift_cipher: testbench top for the three-rotor shift cipher
// Drives character beats and register settings into the cipher, lets a
// separate checker predict and compare every result, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_three_rotor_shift_cipher
   import rsc_pkg::*;
;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASES         = 6;
   localparam int unsigned PHASE_CHARS    = 122;
   localparam int unsigned SQUEEZE_PHASE  = 2;
   localparam int unsigned SQUEEZE_CYCLES = 64;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Raised by the stimulus when it wants the receiver to hold off for a
   // long stretch while the sender keeps pushing characters.
   logic                  squeeze_req = 1'b0;

   int unsigned fail_count;
   int unsigned pending_beats;
   int unsigned result_count;
   int unsigned chars_sent    = 0;
   int unsigned starts_sent   = 0;
   int unsigned settings_used = 0;
   int unsigned idle_cycles   = 0;

   three_rotor_shift_cipher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rsc_cipher_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .result_count  (result_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one character beat and returns at the edge that accepts it. The
   // valid stays high on return so that back-to-back beats need no gap.
   task automatic send_char(input logic [7:0] ch, input logic start);
      req_type beat;
      beat.char_in       = ch;
      beat.message_start = start;
      req_valid <= 1'b1;
      req_data  <= beat;
      chars_sent  = chars_sent + 1;
      starts_sent = starts_sent + start;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Registers only change with the pipeline empty. One edge is spent first
   // so that the checker has counted the last accepted beat, and the writes
   // wait until every predicted result has come back.
   task automatic configure(input logic [3:0] mode_w, input logic [3:0] fast_w,
                            input logic [3:0] middle_w, input logic [3:0] slow_w);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DECRYPT_MODE;
      csr_wdata <= mode_w;
      @(posedge clock);
      csr_index <= CSR_START_POS_FAST;
      csr_wdata <= fast_w;
      @(posedge clock);
      csr_index <= CSR_START_POS_MIDDLE;
      csr_wdata <= middle_w;
      @(posedge clock);
      csr_index <= CSR_START_POS_SLOW;
      csr_wdata <= slow_w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used = settings_used + 1;
   endtask

   // Mostly alphabet characters so the shift path gets most of the traffic;
   // the rest is any byte at all, which exercises the pass-through path.
   function automatic logic [7:0] pick_char();
      int unsigned k;
      if ($urandom_range(0, 9) < 8) begin
         k = $urandom_range(0, 26);
         return (k == 26) ? SPACE_CHAR : 8'(CHAR_A + k);
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Receiver: stall patterns of random kind and length, and once a long
   // hold-off so that both pipeline stages fill and the input stalls.
   initial begin : receiver
      int unsigned mode;
      int unsigned span;
      bit          squeezed;
      squeezed = 1'b0;
      forever begin
         if (squeeze_req && !squeezed) begin
            squeezed = 1'b1;
            repeat (SQUEEZE_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span) begin
               @(posedge clock);
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 1) == 1);
                  2:       rsp_stall <= ($urandom_range(0, 4) == 0);
                  default: rsp_stall <= ($urandom_range(0, 4) != 0);
               endcase
            end
         end
      end
   end

   // Watchdog: any accepted beat on either channel counts as progress.
   initial begin : watchdog
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned left;
      int unsigned burst;
      bit          first;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: encrypt with all rotors at zero. Alphabet edges and
      // bytes just outside the alphabet on both sides.
      send_char("A", 1'b1);
      send_char("Z", 1'b0);
      send_char(" ", 1'b0);
      send_char(8'h40, 1'b0);
      send_char(8'h5b, 1'b0);
      send_char(8'h1f, 1'b0);
      send_char(8'h21, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'hff, 1'b1);

      // Start positions above nine saturate; the decrypt mode uses only its
      // low bit. Rotors start at 999 and the step after the first character wraps all three.
      configure(4'hf, 4'hf, 4'ha, 4'hc);
      send_char("A", 1'b1);
      send_char("B", 1'b0);
      send_char(" ", 1'b0);

      // Largest key (all rotors at four), encrypting with upper bits set.
      configure(4'he, 4'd4, 4'd4, 4'd4);
      send_char("A", 1'b1);
      send_char(" ", 1'b0);

      // Zero key (all rotors at two), decrypting.
      configure(4'h1, 4'd2, 4'd2, 4'd2);
      send_char("A", 1'b1);
      send_char(" ", 1'b1);

      // New start positions only matter at the next message start: the first
      // character keeps stepping from where the rotors were.
      configure(4'h0, 4'd7, 4'd3, 4'd1);
      send_char("M", 1'b0);
      send_char("N", 1'b1);
      send_char("O", 1'b0);

      // Random phases, each with its own register setting. Every phase opens
      // a message and new messages start now and then inside it.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       configure(4'h0, 4'h0, 4'h0, 4'h0);
            1:       configure(4'h1, 4'h9, 4'h9, 4'h9);
            default: configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                               4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         endcase
         if (phase == SQUEEZE_PHASE)
            squeeze_req <= 1'b1;
         left  = PHASE_CHARS;
         first = 1'b1;
         while (left > 0) begin
            // The squeeze phase opens with one long unbroken burst so that
            // characters keep coming while the receiver holds off.
            burst = (phase == SQUEEZE_PHASE && first) ? 120 : $urandom_range(1, 24);
            if (burst > left)
               burst = left;
            repeat (burst) begin
               send_char(pick_char(), first || ($urandom_range(0, 15) == 0));
               first = 1'b0;
               left  = left - 1;
            end
            if (left > 0)
               pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         end
         if (phase == SQUEEZE_PHASE)
            squeeze_req <= 1'b0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d characters (%0d message starts) over %0d register settings,",
               chars_sent, starts_sent, settings_used);
      $display("including a long receiver hold-off; %0d results compared.", result_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
